>>> src/rwm_pkg.sv
// rwm_pkg: shared types, sizes and small helpers of the rgb window median filter
// no dependencies

package rwm_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int MAX_WINDOW  = 5;
    localparam int WIN_CELLS   = MAX_WINDOW * MAX_WINDOW;
    localparam int CELL_W      = $clog2(WIN_CELLS);
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int BANK_W      = $clog2(MAX_WINDOW);
    localparam int HALF_W      = $clog2(MAX_WINDOW);
    localparam int DIM_W       = 11;
    localparam int ROW_W       = DIM_W + 1;
    localparam int LAG_W       = ROW_W + 1;
    localparam int PIX_W       = 24;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_WINDOW_SIZE  = 2'd2
    } cfg_idx_t;

    // one result beat
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } result_t;

    // per-stage control of the pixel pipe
    typedef struct packed {
        logic valid;
        logic emit;
        logic interior;
        logic frame_end;
    } pipe_meta_t;

    // clamp a frame dimension into 1..hi
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) r = DIM_W'(1);
        else if (v > hi) r = hi;
        return r;
    endfunction

    // effective odd window side
    function automatic logic [2:0] eff_window(input logic [2:0] ws);
        logic [2:0] n;
        n = ws;
        if (ws == 3'd0) n = 3'd1;
        else if (ws > 3'(MAX_WINDOW)) n = 3'(MAX_WINDOW);
        if (n[0] == 1'b0) n = n - 3'd1;
        return n;
    endfunction

endpackage

>>> src/rwm_line_bank.sv
// rwm_line_bank: one row store of the line buffer ring, one write and one read port
// depends on rwm_pkg

module rwm_line_bank (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [rwm_pkg::COL_W-1:0] addr,
    input  logic [rwm_pkg::PIX_W-1:0] wr_data,
    input  logic                      rd_en,
    output logic [rwm_pkg::PIX_W-1:0] rd_data
);
    import rwm_pkg::*;

    logic [PIX_W-1:0] mem [MAX_WIDTH];
    logic [PIX_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/rwm_median_lane.sv
// rwm_median_lane: rank-based median of one color channel over the window, two stages
// depends on rwm_pkg

module rwm_median_lane (
    input  logic                                     aclk,
    input  logic [rwm_pkg::WIN_CELLS-1:0][7:0]       cell_vals,
    input  logic [rwm_pkg::WIN_CELLS-1:0]            cell_mask,
    input  logic [rwm_pkg::CELL_W-1:0]               rank_target,
    output logic [7:0]                               median
);
    import rwm_pkg::*;

    logic [WIN_CELLS-1:0][7:0] vals_reg;
    logic [WIN_CELLS-1:0]      mask_reg;
    logic [CELL_W-1:0]         target_reg;
    logic [WIN_CELLS-1:0]      lt_reg   [WIN_CELLS];
    logic [WIN_CELLS-1:0]      lt_next  [WIN_CELLS];
    logic [7:0]                median_reg;
    logic [7:0]                median_next;

    // pairwise compare, ties broken by cell index
    always_comb begin
        for (int i = 0; i < WIN_CELLS; i++) begin
            for (int j = 0; j < WIN_CELLS; j++) begin
                lt_next[i][j] = cell_mask[j] &&
                                ((cell_vals[j] < cell_vals[i]) ||
                                 ((cell_vals[j] == cell_vals[i]) && (j < i)));
            end
        end
    end

    always_ff @(posedge aclk) begin
        vals_reg   <= cell_vals;
        mask_reg   <= cell_mask;
        target_reg <= rank_target;
        for (int i = 0; i < WIN_CELLS; i++) begin
            lt_reg[i] <= lt_next[i];
        end
    end

    // pick the cell whose rank is the middle one
    always_comb begin
        median_next = '0;
        for (int i = 0; i < WIN_CELLS; i++) begin
            if (mask_reg[i] && (CELL_W'($countones(lt_reg[i])) == target_reg)) begin
                median_next = median_next | vals_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        median_reg <= median_next;
    end

    assign median = median_reg;

endmodule

>>> src/rwm_out_fifo.sv
// rwm_out_fifo: small result queue between the pixel pipe and the output channel
// depends on rwm_pkg

module rwm_out_fifo (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           push,
    input  rwm_pkg::result_t               push_data,
    input  logic                           pop,
    output rwm_pkg::result_t               head,
    output logic                           not_empty,
    output logic [rwm_pkg::FIFO_CNT_W-1:0] count
);
    import rwm_pkg::*;

    result_t                mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]  count_reg, count_next;
    logic                   do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb begin
        wr_ptr_next = push   ? wr_ptr_reg + FIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + FIFO_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop) count_next = count_reg + FIFO_CNT_W'(1);
        else if (!push && do_pop) count_next = count_reg - FIFO_CNT_W'(1);
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign head      = mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

>>> src/rgb_window_median_filter_unit.sv
// rgb_window_median_filter_unit: streaming per-channel 2d median over an n x n window
// depends on rwm_pkg, rwm_line_bank, rwm_median_lane, rwm_out_fifo
//
//  channel  ports                              role
//  s_       valid ready red green blue drain   pixel or drain beat in
//  m_       valid ready out_red/green/blue     filtered pixel beat out, frame_end flag
//  cfg_     valid ready index data             register write, always ready
//
// one beat per cycle while queue space covers the pipe; a result leaves through bank read,
// window shift, compare stage, rank stage and queue after the beat that completes its window
// line stores are five row banks read in parallel at the input column on each advancing beat
// reset: counters and queue cleared, registers to 640 x 480 and window 3, no clearing pass
// output stalls are absorbed by an 8-entry queue; input is held off only when queue
// space would not cover the results still in the pipe

module rgb_window_median_filter_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_red,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_blue,
    input  logic        s_drain,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_red,
    output logic [7:0]  m_out_green,
    output logic [7:0]  m_out_blue,
    output logic        m_frame_end,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);
    import rwm_pkg::*;

    // configuration
    logic [DIM_W-1:0] frame_width_reg;
    logic [DIM_W-1:0] frame_height_reg;
    logic [2:0]       window_size_reg;
    logic             cfg_wr;

    logic [DIM_W-1:0]  w_eff, h_eff;
    logic [2:0]        n_eff;
    logic [HALF_W-1:0] half;
    logic [LAG_W-1:0]  lag;
    logic [CELL_W-1:0] rank_target;

    // stream counters
    logic [COL_W-1:0]  in_col_reg,  in_col_next;
    logic [ROW_W-1:0]  in_row_reg,  in_row_next;
    logic [BANK_W-1:0] in_bank_reg, in_bank_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic [LAG_W-1:0]  diff_reg,    diff_next;

    logic accept, in_frame, advance, wr_pix, emit, interior, last_pix;

    // pipe
    pipe_meta_t        meta0, s1_reg, s2_reg, s3_reg, s4_reg;
    logic [PIX_W-1:0]  s1_pix_reg;
    logic [BANK_W-1:0] s1_bank_reg;
    logic [PIX_W-1:0]  bank_rd [MAX_WINDOW];
    logic [PIX_W-1:0]  win_reg [MAX_WINDOW][MAX_WINDOW];
    logic [PIX_W-1:0]  new_col [MAX_WINDOW];
    logic [PIX_W-1:0]  center;
    logic [PIX_W-1:0]  s3_center_reg, s4_center_reg;

    logic [WIN_CELLS-1:0][7:0] cells_r, cells_g, cells_b;
    logic [WIN_CELLS-1:0]      cell_mask;
    logic [7:0]                med_r, med_g, med_b;

    result_t               push_data, head;
    logic                  push;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic                  fifo_not_empty;
    logic [FIFO_CNT_W:0]   credit_used;

    // effective geometry
    assign w_eff = clamp_dim(frame_width_reg, DIM_W'(MAX_WIDTH));
    assign h_eff = clamp_dim(frame_height_reg, DIM_W'(MAX_HEIGHT));
    assign n_eff = eff_window(window_size_reg);
    assign half  = HALF_W'(n_eff >> 1);
    assign lag   = (LAG_W'(half) * LAG_W'(w_eff)) + LAG_W'(half);
    assign rank_target = (CELL_W'(n_eff) * CELL_W'(n_eff)) >> 1;

    // config port
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= DIM_W'(640);
            frame_height_reg <= DIM_W'(480);
            window_size_reg  <= 3'd3;
        end else if (cfg_wr) begin
            case (cfg_idx_t'(cfg_index))
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                CFG_WINDOW_SIZE:  window_size_reg  <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // beat classification
    assign accept   = s_valid && s_ready;
    assign in_frame = (in_row_reg < ROW_W'(h_eff));
    assign advance  = accept && !(in_frame && s_drain);
    assign wr_pix   = advance && in_frame;
    assign emit     = advance && (out_row_reg < ROW_W'(h_eff)) && (diff_reg >= lag);
    assign interior = (out_row_reg >= ROW_W'(half)) &&
                      ((out_row_reg + ROW_W'(half)) < ROW_W'(h_eff)) &&
                      ({1'b0, out_col_reg} >= DIM_W'(half)) &&
                      (({1'b0, out_col_reg} + DIM_W'(half)) < w_eff);
    assign last_pix = (out_row_reg == ROW_W'(h_eff - DIM_W'(1))) &&
                      ({1'b0, out_col_reg} == (w_eff - DIM_W'(1)));

    // counter next values
    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        in_bank_next = in_bank_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        diff_next    = diff_reg;
        if (advance) begin
            if ({1'b0, in_col_reg} == (w_eff - DIM_W'(1))) begin
                in_col_next  = '0;
                in_row_next  = in_row_reg + ROW_W'(1);
                in_bank_next = (in_bank_reg == BANK_W'(MAX_WINDOW - 1)) ? '0
                               : in_bank_reg + BANK_W'(1);
            end else begin
                in_col_next = in_col_reg + COL_W'(1);
            end
            if (!emit) diff_next = diff_reg + LAG_W'(1);
            if (emit) begin
                if ({1'b0, out_col_reg} == (w_eff - DIM_W'(1))) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ROW_W'(1);
                end else begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
                if (last_pix) begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    in_bank_next = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                    diff_next    = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            in_bank_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            diff_reg    <= '0;
        end else begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            in_bank_reg <= in_bank_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            diff_reg    <= diff_next;
        end
    end

    // line store ring, one bank per row
    for (genvar b = 0; b < MAX_WINDOW; b++) begin : g_bank
        rwm_line_bank u_bank (
            .aclk    (aclk),
            .wr_en   (wr_pix && (in_bank_reg == BANK_W'(b))),
            .addr    (in_col_reg),
            .wr_data ({s_red, s_green, s_blue}),
            .rd_en   (advance),
            .rd_data (bank_rd[b])
        );
    end

    assign meta0 = '{valid: advance, emit: emit, interior: interior, frame_end: last_pix};

    // pipe control, stage 1 holds the incoming pixel beside the bank reads
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
            s4_reg <= '0;
        end else begin
            s1_reg <= meta0;
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
            s4_reg <= s3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_pix_reg  <= {s_red, s_green, s_blue};
            s1_bank_reg <= in_bank_reg;
        end
    end

    // newest column: row 0 is the live pixel, older rows come from the ring
    always_comb begin
        logic [BANK_W:0] sel;
        new_col[0] = s1_pix_reg;
        for (int k = 1; k < MAX_WINDOW; k++) begin
            sel = {1'b0, s1_bank_reg} + (BANK_W+1)'(MAX_WINDOW - k);
            if (sel >= (BANK_W+1)'(MAX_WINDOW)) sel = sel - (BANK_W+1)'(MAX_WINDOW);
            new_col[k] = bank_rd[sel[BANK_W-1:0]];
        end
    end

    // window shift, column 0 is the newest
    always_ff @(posedge aclk) begin
        if (s1_reg.valid) begin
            for (int k = 0; k < MAX_WINDOW; k++) begin
                for (int c = MAX_WINDOW - 1; c > 0; c--) begin
                    win_reg[k][c] <= win_reg[k][c-1];
                end
                win_reg[k][0] <= new_col[k];
            end
        end
    end

    // lane inputs and active cells
    always_comb begin
        for (int k = 0; k < MAX_WINDOW; k++) begin
            for (int c = 0; c < MAX_WINDOW; c++) begin
                cells_r[k*MAX_WINDOW + c]   = win_reg[k][c][23:16];
                cells_g[k*MAX_WINDOW + c]   = win_reg[k][c][15:8];
                cells_b[k*MAX_WINDOW + c]   = win_reg[k][c][7:0];
                cell_mask[k*MAX_WINDOW + c] = (3'(k) < n_eff) && (3'(c) < n_eff);
            end
        end
    end

    assign center = win_reg[half][half];

    always_ff @(posedge aclk) begin
        s3_center_reg <= center;
        s4_center_reg <= s3_center_reg;
    end

    rwm_median_lane u_lane_r (
        .aclk(aclk), .cell_vals(cells_r), .cell_mask(cell_mask),
        .rank_target(rank_target), .median(med_r)
    );
    rwm_median_lane u_lane_g (
        .aclk(aclk), .cell_vals(cells_g), .cell_mask(cell_mask),
        .rank_target(rank_target), .median(med_g)
    );
    rwm_median_lane u_lane_b (
        .aclk(aclk), .cell_vals(cells_b), .cell_mask(cell_mask),
        .rank_target(rank_target), .median(med_b)
    );

    // merge lanes, edge pixels pass unchanged
    assign push = s4_reg.valid && s4_reg.emit;
    always_comb begin
        if (s4_reg.interior) begin
            push_data = '{red: med_r, green: med_g, blue: med_b,
                          frame_end: s4_reg.frame_end};
        end else begin
            push_data = '{red: s4_center_reg[23:16], green: s4_center_reg[15:8],
                          blue: s4_center_reg[7:0], frame_end: s4_reg.frame_end};
        end
    end

    rwm_out_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (m_ready),
        .head      (head),
        .not_empty (fifo_not_empty),
        .count     (fifo_count)
    );

    // queue space must cover every result still in the pipe
    assign credit_used = {1'b0, fifo_count}
                         + (FIFO_CNT_W+1)'(s1_reg.valid && s1_reg.emit)
                         + (FIFO_CNT_W+1)'(s2_reg.valid && s2_reg.emit)
                         + (FIFO_CNT_W+1)'(s3_reg.valid && s3_reg.emit)
                         + (FIFO_CNT_W+1)'(s4_reg.valid && s4_reg.emit);
    assign s_ready = (credit_used < (FIFO_CNT_W+1)'(FIFO_DEPTH));

    assign m_valid     = fifo_not_empty;
    assign m_out_red   = head.red;
    assign m_out_green = head.green;
    assign m_out_blue  = head.blue;
    assign m_frame_end = head.frame_end;

`ifndef ASSERT_OFF
    // queue plus in-flight results never exceed the queue depth
    a_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        credit_used <= (FIFO_CNT_W+1)'(FIFO_DEPTH))
        else $error("result credit overrun");

    // input to output distance never passes the window lag
    a_diff: assert property (@(posedge aclk) disable iff (!aresetn)
        diff_reg <= lag)
        else $error("stream distance beyond lag");

    // the last pixel of a frame restarts both counters
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && last_pix) |=> (out_row_reg == '0 && out_col_reg == '0 &&
                                in_row_reg == '0 && diff_reg == '0))
        else $error("frame did not restart");

    // a result is only queued when the pipe carries an emitting beat
    a_push: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> $past(s3_reg.valid && s3_reg.emit))
        else $error("result without source beat");
`endif

endmodule

>>> test/rgb_window_median_filter_unit_tb.sv
// rgb_window_median_filter_unit_tb: self-checking bench for the rgb window median filter
// depends on rwm_pkg and rgb_window_median_filter_unit; a directed table, then random frames
// checked against a bit-exact median predictor
`timescale 1ns / 100ps

module rgb_window_median_filter_unit_tb;
    import rwm_pkg::*;

    localparam logic [1:0] CFG_SPARE_IDX = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_PIXELS = 950;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_red = '0, s_green = '0, s_blue = '0;
    logic        s_drain = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_red, m_out_green, m_out_blue;
    logic        m_frame_end;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [10:0] cfg_data = '0;

    rgb_window_median_filter_unit uut (.*);

    always #5 aclk = ~aclk;

    // predictor state
    logic [23:0] row_mem [MAX_WINDOW*MAX_WIDTH];
    logic [10:0] width_reg = 11'd640, height_reg = 11'd480;
    logic [2:0]  win_reg = 3'd3;
    int unsigned in_pos = 0, out_pos = 0;

    result_t     pixel_q [$];
    int          errors = 0;
    int unsigned cycles = 0;
    bit          quiet = 1'b0;
    int          stall = 0;

    function automatic int unsigned dim_of(logic [10:0] v, int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int unsigned side_of();
        int unsigned n;
        n = (win_reg == 0) ? 1 : (win_reg > MAX_WINDOW) ? MAX_WINDOW : win_reg;
        if (n % 2 == 0) n = n - 1;
        return n;
    endfunction

    function automatic int unsigned mem_addr(int unsigned row, int unsigned col);
        return (row % MAX_WINDOW) * MAX_WIDTH + (col % MAX_WIDTH);
    endfunction

    // median of one byte lane over the gathered window
    function automatic logic [7:0] lane_median(logic [23:0] win [25], int unsigned cnt,
                                               int shift);
        logic [7:0] v [25];
        logic [7:0] x;
        int j;
        for (int i = 0; i < cnt; i++) begin
            x = 8'(win[i] >> shift);
            j = i;
            while (j > 0 && v[j-1] > x) begin
                v[j] = v[j-1];
                j--;
            end
            v[j] = x;
        end
        return v[cnt/2];
    endfunction

    // advance the filter by one accepted beat, returns 1 when a pixel comes out
    function automatic bit filter_step(logic [23:0] pix_in, bit drain, output result_t res);
        int unsigned w, h, n, half, total, lag, row, col, k;
        logic [23:0] pix;
        logic [23:0] win [25];
        w = dim_of(width_reg, MAX_WIDTH);
        h = dim_of(height_reg, MAX_HEIGHT);
        n = side_of();
        half = n / 2;
        total = w * h;
        lag = half * w + half;
        res = '0;
        if (in_pos < total) begin
            if (drain) return 0;
            row_mem[mem_addr(in_pos / w, in_pos % w)] = pix_in;
        end
        in_pos++;
        if (out_pos >= total || in_pos < out_pos + lag + 1) return 0;
        row = out_pos / w;
        col = out_pos % w;
        pix = row_mem[mem_addr(row, col)];
        if (row >= half && row + half < h && col >= half && col + half < w) begin
            k = 0;
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n; j++)
                    win[k++] = row_mem[mem_addr(row + i - half, col + j - half)];
            pix = {lane_median(win, k, 16), lane_median(win, k, 8), lane_median(win, k, 0)};
        end
        res.red = pix[23:16];
        res.green = pix[15:8];
        res.blue = pix[7:0];
        res.frame_end = (out_pos + 1 == total);
        out_pos++;
        if (out_pos >= total) begin
            in_pos = 0;
            out_pos = 0;
        end
        return 1;
    endfunction

    // wait for all pixels out, then let the pipe settle
    task automatic wait_idle();
        while (pixel_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [10:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_FRAME_WIDTH: width_reg = data;
            CFG_FRAME_HEIGHT: height_reg = data;
            CFG_WINDOW_SIZE: win_reg = data[2:0];
            default: ;
        endcase
        if (idx != CFG_SPARE_IDX) begin
            in_pos = 0;
            out_pos = 0;
        end
    endtask

    // one input beat; typed expectation replaces the predicted one when given
    task automatic send_beat(logic [23:0] pix, bit drain, bit typed, result_t typed_res,
                             output bit frame_done);
        result_t res;
        s_valid <= 1'b1;
        {s_red, s_green, s_blue} <= pix;
        s_drain <= drain;
        do @(posedge aclk); while (!s_ready);
        frame_done = 1'b0;
        if (filter_step(pix, drain, res)) begin
            pixel_q.push_back(typed ? typed_res : res);
            frame_done = res.frame_end;
        end
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    function automatic logic [23:0] rand_pixel();
        logic [23:0] p;
        p = 24'($urandom);
        if ($urandom_range(0, 5) == 0) p[23:16] = $urandom_range(0, 1) ? 8'hff : 8'h00;
        if ($urandom_range(0, 5) == 0) p[15:8] = $urandom_range(0, 1) ? 8'hff : 8'h00;
        if ($urandom_range(0, 5) == 0) p[7:0] = $urandom_range(0, 1) ? 8'hff : 8'h00;
        return p;
    endfunction

    // stream whole frames with stray drains inside and stray pixels after
    task automatic run_frames(int nframes, inout int pixels);
        bit done, in_frame;
        int unsigned total;
        int frames;
        result_t none;
        none = '0;
        frames = 0;
        while (frames < nframes) begin
            total = dim_of(width_reg, MAX_WIDTH) * dim_of(height_reg, MAX_HEIGHT);
            in_frame = in_pos < total;
            if (in_frame ? $urandom_range(0, 9) != 0 : $urandom_range(0, 4) == 0) begin
                send_beat(rand_pixel(), 1'b0, 1'b0, none, done);
            end else begin
                send_beat(rand_pixel(), 1'b1, 1'b0, none, done);
            end
            pixels++;
            if (done) frames++;
            if (!quiet && $urandom_range(0, 299) == 0) begin
                s_valid <= 1'b0;
                wait_idle();
            end
        end
        s_valid <= 1'b0;
    endtask

    typedef struct {
        bit          is_cfg;
        logic [1:0]  idx;
        logic [10:0] data;
        logic [23:0] pix;
        bit          drain;
        bit          typed;
        result_t     res;
    } dir_row_t;

    function automatic dir_row_t cfg_row(logic [1:0] idx, logic [10:0] data);
        dir_row_t r;
        r = '{1'b1, idx, data, 24'h0, 1'b0, 1'b0, '0};
        return r;
    endfunction

    function automatic dir_row_t px_row(logic [23:0] pix, bit drain, bit typed, bit fe);
        dir_row_t r;
        r = '{1'b0, 2'd0, 11'd0, pix, drain, typed, {pix, fe}};
        return r;
    endfunction

    // result receiver with random stall bursts
    always @(posedge aclk) begin
        if (stall > 0) begin
            stall <= stall - 1;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall <= $urandom_range(0, 18);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pixel_q.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual %h %h %h fe=%b", $time,
                         m_out_red, m_out_green, m_out_blue, m_frame_end);
                errors++;
            end else begin
                e = pixel_q.pop_front();
                if (m_out_red !== e.red || m_out_green !== e.green ||
                    m_out_blue !== e.blue || m_frame_end !== e.frame_end) begin
                    $display("%0t: mismatch, expected %h %h %h fe=%b, actual %h %h %h fe=%b",
                             $time, e.red, e.green, e.blue, e.frame_end,
                             m_out_red, m_out_green, m_out_blue, m_frame_end);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        dir_row_t rows [$];
        result_t none;
        bit done;
        int pixels;
        none = '0;
        pixels = 0;

        // directed table: pass-through first, then a tiny 3x3 frame
        rows = '{
            cfg_row(CFG_FRAME_WIDTH, 11'd2), cfg_row(CFG_FRAME_HEIGHT, 11'd1),
            cfg_row(CFG_WINDOW_SIZE, 11'd1),
            px_row(24'h000000, 1'b0, 1'b1, 1'b0), px_row(24'hffffff, 1'b0, 1'b1, 1'b1),
            px_row(24'h0, 1'b1, 1'b0, 1'b0),
            px_row(24'h123456, 1'b0, 1'b1, 1'b0), px_row(24'habcdef, 1'b0, 1'b1, 1'b1),
            cfg_row(CFG_WINDOW_SIZE, 11'd0), cfg_row(CFG_SPARE_IDX, 11'h7ff),
            px_row(24'h807f01, 1'b0, 1'b1, 1'b0), px_row(24'h01807f, 1'b0, 1'b1, 1'b1),
            cfg_row(CFG_FRAME_WIDTH, 11'd3), cfg_row(CFG_FRAME_HEIGHT, 11'd3),
            cfg_row(CFG_WINDOW_SIZE, 11'd4),
            px_row(24'hff00ff, 1'b0, 1'b0, 1'b0), px_row(24'h00ff00, 1'b0, 1'b0, 1'b0),
            px_row(24'h0, 1'b1, 1'b0, 1'b0),
            px_row(24'h7f7f7f, 1'b0, 1'b0, 1'b0), px_row(24'hffffff, 1'b0, 1'b0, 1'b0),
            px_row(24'h000000, 1'b0, 1'b0, 1'b0), px_row(24'h102030, 1'b0, 1'b0, 1'b0),
            px_row(24'hfe01fe, 1'b0, 1'b0, 1'b0), px_row(24'h80c040, 1'b0, 1'b0, 1'b0),
            px_row(24'h55aa55, 1'b0, 1'b0, 1'b0),
            px_row(24'h0, 1'b1, 1'b0, 1'b0), px_row(24'h0, 1'b1, 1'b0, 1'b0),
            px_row(24'h0, 1'b1, 1'b0, 1'b0), px_row(24'h999999, 1'b0, 1'b0, 1'b0)
        };

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                s_valid <= 1'b0;
                wait_idle();
                write_reg(rows[i].idx, rows[i].data);
            end else begin
                send_beat(rows[i].pix, rows[i].drain, rows[i].typed, rows[i].res, done);
            end
        end
        s_valid <= 1'b0;

        // extreme registers: zero dimensions act as one, window beyond the frame
        wait_idle();
        write_reg(CFG_FRAME_WIDTH, 11'd0);
        write_reg(CFG_FRAME_HEIGHT, 11'd0);
        write_reg(CFG_WINDOW_SIZE, 11'd7);
        run_frames(2, pixels);

        // random phases of small frames
        while (pixels < RANDOM_PIXELS) begin
            wait_idle();
            if (pixels > RANDOM_PIXELS - 120) quiet = 1'b1;
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_FRAME_WIDTH, 11'($urandom_range(0, 12)));
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_FRAME_HEIGHT, 11'($urandom_range(0, 10)));
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_WINDOW_SIZE, $urandom_range(0, 1) ? 11'($urandom_range(0, 7))
                                                                : 11'($urandom));
            run_frames($urandom_range(1, 3), pixels);
        end

        // drain out
        while (pixel_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
